FILE: sv/pcbd_pkg.sv
`timescale 1ns / 1ps
// Package for the prefix code bit decoder: beat types, request codes, sizes.
// No dependencies; imported by every module of the block.
package pcbd_pkg;

  localparam int IDX_W = 5;
  localparam int CODE_W = 16;
  localparam int LEN_W = 5;
  localparam int CHAR_W = 7;

  localparam int TABLE_SLOTS = 32;
  localparam int DEF_NUM_SYMBOLS = 32;
  localparam int DEF_MAX_CODE_LEN = 16;

  localparam int QDEPTH = 2;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'd32;
  localparam logic [CHAR_W-1:0] CHAR_BASE = 7'd64;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  entry_index;
    logic [CODE_W-1:0] entry_code;
    logic [LEN_W-1:0]  entry_length;
    logic              bit_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  symbol_index;
    logic [CHAR_W-1:0] symbol_char;
    logic              decode_error;
  } out_item_t;

endpackage

FILE: sv/prefix_code_bit_decoder_core.sv
`timescale 1ns / 1ps
// Top level of the bit-serial prefix code decoder: front queue plus decode back end.
// Depends on pcbd_pkg, pcbd_front, pcbd_back.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     in_data  (in_item_t)
//   out      output     out_valid / out_stall   out_data (out_item_t)
//
// One beat per cycle unless stalled; the back end pops one queued beat per cycle.
// A bit completing a code word passes the queue and then the result register to out.
// Reset clears the length table, prefix, queue and out_valid, but not out_data.
// in_stall rises only when the two-entry queue is full; out_stall holds the result
// register and, through it, decode beats in the queue; load beats still retire.
module prefix_code_bit_decoder_core import pcbd_pkg::*; #(
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS,
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic     q_valid;
  in_item_t q_item;
  logic     q_pop;

  pcbd_front #(
    .NUM_SYMBOLS(NUM_SYMBOLS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .q_valid(q_valid),
    .q_item(q_item),
    .q_pop(q_pop)
  );

  pcbd_back #(
    .NUM_SYMBOLS(NUM_SYMBOLS),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_item(q_item),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule

FILE: sv/pcbd_front.sv
`timescale 1ns / 1ps
// Front end: accepts input beats, drops loads beyond the table, queues the rest.
// Depends on pcbd_pkg.
module pcbd_front import pcbd_pkg::*; #(
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  output in_item_t q_item,
  input  logic     q_pop
);

  localparam int TBL_DEPTH = (NUM_SYMBOLS < TABLE_SLOTS) ? NUM_SYMBOLS : TABLE_SLOTS;
  localparam int QPW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);
  localparam logic [IDX_W:0] DEPTH_LIM = (IDX_W + 1)'(TBL_DEPTH);

  in_item_t         mem [QDEPTH];
  logic [QPW-1:0]   wr_ptr;
  logic [QPW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;
  logic             keep;
  logic             push;
  logic             pop;

  assign in_stall = (count == QCW'(QDEPTH));
  assign keep = (in_data.req_type == REQ_DECODE) || ({1'b0, in_data.entry_index} < DEPTH_LIM);
  assign push = in_valid && !in_stall && keep;
  assign pop = q_pop && q_valid;
  assign q_valid = (count != '0);
  assign q_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPW'(1);
      end
      if (push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (count != '0))
    else $error("pop from empty queue");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < QCW'(QDEPTH)))
    else $error("push into full queue");
`endif

endmodule

FILE: sv/pcbd_back.sv
`timescale 1ns / 1ps
// Back end: code and length tables, running prefix, parallel match, result register.
// Depends on pcbd_pkg.
module pcbd_back import pcbd_pkg::*; #(
  parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS,
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  in_item_t  q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int TBL_DEPTH = (NUM_SYMBOLS < TABLE_SLOTS) ? NUM_SYMBOLS : TABLE_SLOTS;
  localparam int IW = $clog2(TBL_DEPTH);
  localparam int PW = MAX_CODE_LEN;
  localparam int LW = $clog2(MAX_CODE_LEN + 1);

  logic [CODE_W-1:0]  code_tbl [TBL_DEPTH];
  logic [LEN_W-1:0]   len_tbl [TBL_DEPTH];
  logic [PW-1:0]      prefix;
  logic [PW-1:0]      prefix_next;
  logic [LW-1:0]      plen;
  logic [LW-1:0]      plen_next;
  logic [TBL_DEPTH-1:0] hit_vec;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic               full_len;
  logic               out_free;
  logic               dec;
  logic               emit;
  logic               load;

  assign prefix_next = {prefix[PW-2:0], q_item.bit_value};
  assign plen_next = plen + LW'(1);
  assign full_len = (plen_next == LW'(MAX_CODE_LEN));
  assign out_free = !out_valid || !out_stall;
  assign q_pop = q_valid && ((q_item.req_type == REQ_LOAD) || out_free);
  assign dec = q_pop && (q_item.req_type == REQ_DECODE);
  assign load = q_pop && (q_item.req_type == REQ_LOAD);
  assign emit = dec && (hit || full_len);

  always_comb begin
    for (int i = 0; i < TBL_DEPTH; i++) begin
      hit_vec[i] = (len_tbl[i] != '0) &&
                   ({1'b0, len_tbl[i]} == (LEN_W + 1)'(plen_next)) &&
                   ((32'(code_tbl[i]) & ((32'd1 << len_tbl[i]) - 32'd1)) ==
                    32'(prefix_next));
    end
  end

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int i = TBL_DEPTH - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_tbl[q_item.entry_index[IW-1:0]] <= q_item.entry_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TBL_DEPTH; i++) begin
        len_tbl[i] <= '0;
      end
    end else if (load) begin
      len_tbl[q_item.entry_index[IW-1:0]] <= q_item.entry_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= '0;
      plen <= '0;
    end else if (dec) begin
      if (hit || full_len) begin
        prefix <= '0;
        plen <= '0;
      end else begin
        prefix <= prefix_next;
        plen <= plen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.symbol_index <= hit ? hit_idx : '0;
      out_data.symbol_char <= !hit ? '0 :
                              (hit_idx == '0) ? CHAR_SPACE : CHAR_W'(hit_idx) + CHAR_BASE;
      out_data.decode_error <= !hit;
    end
  end

`ifndef SYNTHESIS
  a_plen_bound: assert property (@(posedge clk) disable iff (rst)
    plen < LW'(MAX_CODE_LEN))
    else $error("prefix length reached maximum without clearing");

  a_load_keeps_prefix: assert property (@(posedge clk) disable iff (rst)
    load |=> ($stable(plen) && $stable(prefix)))
    else $error("load beat changed the prefix");

  a_error_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.decode_error) |->
      (out_data.symbol_index == '0 && out_data.symbol_char == '0))
    else $error("error result carries a symbol");
`endif

endmodule

FILE: bench/pcbd_decode_check.sv
`timescale 1ns / 1ps
// Decode checker for the prefix code bit decoder: follows accepted beats on both
// channels, predicts symbols and decode errors, compares them in order. Uses pcbd_pkg.
module pcbd_decode_check import pcbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending,
  output int        symbols_seen,
  output int        errors_seen
);

  localparam int NSYM = (DEF_NUM_SYMBOLS < TABLE_SLOTS) ? DEF_NUM_SYMBOLS : TABLE_SLOTS;
  localparam int MAX_LEN = DEF_MAX_CODE_LEN;

  logic [CODE_W-1:0] word_of [TABLE_SLOTS];
  logic [LEN_W-1:0]  len_of [TABLE_SLOTS];
  logic [CODE_W-1:0] prefix;
  logic [LEN_W-1:0]  prefix_len;
  out_item_t         symbols_due [$];

  task automatic report_mismatch(input string what);
    if (fail_count < 40) begin
      $display("%0t mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  task automatic step_decoder(input in_item_t b);
    out_item_t   r;
    logic [31:0] grown;
    logic [31:0] mask;
    bit          hit;
    hit = 1'b0;
    r = '0;
    if (b.req_type == REQ_LOAD) begin
      if (int'(b.entry_index) < NSYM) begin
        word_of[b.entry_index] = b.entry_code;
        len_of[b.entry_index] = b.entry_length;
      end
      return;
    end
    grown = (32'(prefix) << 1) | 32'(b.bit_value);
    prefix = CODE_W'(grown & ((32'd1 << MAX_LEN) - 32'd1));
    prefix_len = prefix_len + 1'b1;
    for (int i = 0; i < NSYM; i++) begin
      mask = (32'd1 << len_of[i]) - 32'd1;
      if (!hit && len_of[i] != '0 && len_of[i] == prefix_len &&
          (32'(word_of[i]) & mask) == 32'(prefix)) begin
        hit = 1'b1;
        r.symbol_index = IDX_W'(i);
        r.symbol_char = (i == 0) ? CHAR_SPACE : CHAR_BASE + CHAR_W'(i);
      end
    end
    if (!hit && int'(prefix_len) >= MAX_LEN) begin
      hit = 1'b1;
      r = '0;
      r.decode_error = 1'b1;
    end
    if (hit) begin
      symbols_due.push_back(r);
      prefix = '0;
      prefix_len = '0;
    end
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (symbols_due.size() == 0) begin
      report_mismatch($sformatf("unexpected beat idx=%0d char=%0d err=%0b",
                                got.symbol_index, got.symbol_char, got.decode_error));
      return;
    end
    want = symbols_due.pop_front();
    if (got.symbol_index !== want.symbol_index) begin
      report_mismatch($sformatf("symbol_index got %0d want %0d",
                                got.symbol_index, want.symbol_index));
    end
    if (got.symbol_char !== want.symbol_char) begin
      report_mismatch($sformatf("symbol_char got %0d want %0d",
                                got.symbol_char, want.symbol_char));
    end
    if (got.decode_error !== want.decode_error) begin
      report_mismatch($sformatf("decode_error got %0b want %0b",
                                got.decode_error, want.decode_error));
    end
    if (want.decode_error) begin
      errors_seen++;
    end else begin
      symbols_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        word_of[i] = '0;
        len_of[i] = '0;
      end
      prefix = '0;
      prefix_len = '0;
      symbols_due.delete();
      fail_count = 0;
      symbols_seen = 0;
      errors_seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        compare_result(out_data);
      end
      if (in_valid && !in_stall) begin
        step_decoder(in_data);
      end
    end
    pending <= symbols_due.size();
  end

endmodule

FILE: bench/prefix_code_bit_decoder_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for prefix_code_bit_decoder_core: loads code tables, streams coded
// bits with random gaps and stalls, and gives the verdict. Uses pcbd_pkg, pcbd_decode_check.
module prefix_code_bit_decoder_core_tb;
  import pcbd_pkg::*;

  localparam int TARGET_BEATS = 400;
  localparam int HOLD_LEN = 60;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  in_item_t  in_data = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  int fail_count;
  int pending;
  int symbols_seen;
  int errors_seen;
  int beats_sent = 0;
  int tables_loaded = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_cycles = 0;

  logic [CODE_W-1:0] live_code [TABLE_SLOTS];
  int                live_len [TABLE_SLOTS];
  int                live_syms [$];

  always #5 clk = ~clk;

  prefix_code_bit_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  pcbd_decode_check u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .symbols_seen (symbols_seen),
    .errors_seen  (errors_seen)
  );

  task automatic send_beat(input in_item_t b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic load_entry(input int idx, input logic [CODE_W-1:0] code, input int len);
    in_item_t b;
    b = $bits(in_item_t)'($urandom());
    b.req_type = REQ_LOAD;
    b.entry_index = IDX_W'(idx);
    b.entry_code = code;
    b.entry_length = LEN_W'(len);
    send_beat(b);
  endtask

  task automatic decode_bit(input logic v);
    in_item_t b;
    b = $bits(in_item_t)'($urandom());
    b.req_type = REQ_DECODE;
    b.bit_value = v;
    send_beat(b);
  endtask

  task automatic send_symbol(input int s, input int nbits);
    for (int k = live_len[s] - 1; k >= live_len[s] - nbits; k--) begin
      decode_bit(live_code[s][k]);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  // Grow a code tree by splitting leaves, map leaves onto shuffled indexes, retire the rest.
  task automatic load_code_table(input int n, input bit chain, input bit drop);
    logic [CODE_W-1:0] leaf_code [$];
    int                leaf_len [$];
    int                order [$];
    int                prior [$];
    bit                in_use [TABLE_SLOTS];
    logic [CODE_W-1:0] c;
    logic [31:0]       mask;
    int                k;
    int                l;
    int                t;
    leaf_code.push_back('0);
    leaf_len.push_back(0);
    while (leaf_len.size() < n) begin
      k = chain ? leaf_len.size() - 1 : $urandom_range(0, leaf_len.size() - 1);
      if (leaf_len[k] < DEF_MAX_CODE_LEN) begin
        c = leaf_code[k];
        l = leaf_len[k];
        leaf_code.delete(k);
        leaf_len.delete(k);
        leaf_code.push_back({c[CODE_W-2:0], 1'b0});
        leaf_len.push_back(l + 1);
        leaf_code.push_back({c[CODE_W-2:0], 1'b1});
        leaf_len.push_back(l + 1);
      end
    end
    if (drop && leaf_len.size() > 1) begin
      k = $urandom_range(0, leaf_len.size() - 1);
      leaf_code.delete(k);
      leaf_len.delete(k);
    end
    for (int j = 0; j < TABLE_SLOTS; j++) begin
      order.push_back(j);
      in_use[j] = 1'b0;
    end
    for (int j = TABLE_SLOTS - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      t = order[j];
      order[j] = order[k];
      order[k] = t;
    end
    prior = live_syms;
    live_syms.delete();
    foreach (leaf_len[j]) begin
      live_code[order[j]] = leaf_code[j];
      live_len[order[j]] = leaf_len[j];
      live_syms.push_back(order[j]);
      in_use[order[j]] = 1'b1;
    end
    foreach (prior[j]) begin
      if (!in_use[prior[j]]) begin
        load_entry(prior[j], CODE_W'($urandom()),
                   $urandom_range(0, 1) ? 0 : $urandom_range(DEF_MAX_CODE_LEN + 1, 31));
      end
    end
    foreach (live_syms[j]) begin
      mask = (32'd1 << live_len[live_syms[j]]) - 32'd1;
      c = CODE_W'(($urandom() & ~mask) | 32'(live_code[live_syms[j]]));
      load_entry(live_syms[j], c, live_len[live_syms[j]]);
    end
    tables_loaded++;
  endtask

  initial begin : rx_side
    int gap;
    forever begin
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = rx_idle ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid && hold_cycles == 0) @(posedge clk);
    end
  end

  initial begin : stimulus
    int n;
    int s;
    int pick;
    int p;
    bit chain;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // duplicate codes, extra code bits, over-long entry, load mid-prefix, error
    load_entry(31, 16'h0001, 2);
    load_entry(5, 16'hABC5, 2);
    load_entry(0, 16'hFFFC, 2);
    load_entry(7, 16'hFFFF, 31);
    decode_bit(1'b0);
    decode_bit(1'b0);
    decode_bit(1'b0);
    decode_bit(1'b1);
    decode_bit(1'b0);
    load_entry(5, 16'h0000, 0);
    decode_bit(1'b1);
    repeat (DEF_MAX_CODE_LEN) decode_bit(1'b1);
    drain();
    live_syms = {0, 31};

    p = 0;
    while (beats_sent < TARGET_BEATS) begin
      p++;
      tx_idle = (p % 3 != 2);
      rx_idle = (p % 3 != 0);
      chain = ($urandom_range(0, 3) == 0);
      n = chain ? $urandom_range(2, 17) : $urandom_range(2, 32);
      load_code_table(n, chain, $urandom_range(0, 1));
      if (p == 1 || p == 4) begin
        hold_cycles = HOLD_LEN;
      end
      repeat ($urandom_range(8, 16)) begin
        pick = $urandom_range(0, 9);
        s = live_syms[$urandom_range(0, live_syms.size() - 1)];
        if (pick < 8) begin
          send_symbol(s, live_len[s]);
        end else if (pick == 8) begin
          send_symbol(s, $urandom_range(1, live_len[s]));
        end else begin
          repeat ($urandom_range(1, 20)) decode_bit($urandom_range(0, 1));
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("run: %0d beats over %0d random code tables plus directed cases", beats_sent,
             tables_loaded);
    $display("run: %0d symbols and %0d decode errors compared", symbols_seen, errors_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
